@@ hw/rtl/learning_rate_scheduler_assert.svh @@
// Assertion macros shared by the scheduler modules.
// Define ASSERT_OFF to compile every check away.
`ifndef LEARNING_RATE_SCHEDULER_ASSERT_SVH
`define LEARNING_RATE_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define LRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define LRS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LRS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hw/rtl/lrs_pkg.sv @@
package lrs_pkg;

  localparam int unsigned RateW = 32;
  localparam int unsigned IterW = 31;
  localparam int unsigned CntW  = 16;
  localparam int unsigned AddrW = 5;

  localparam logic [RateW-1:0] OneQ24 = 32'h0100_0000;

  // Register reset values.
  localparam logic                    ModeRst       = 1'b0;
  localparam logic [RateW-1:0]        InitRateRst   = 32'd167772;
  localparam logic [IterW-1:0]        WarmupRst     = 31'd0;
  localparam logic [RateW-1:0]        DecayRst      = 32'd16609444;
  localparam logic [RateW-1:0]        GrowthRst     = 32'd18454938;
  localparam logic signed [RateW-1:0] GrowthThrRst  = 32'sd167772;
  localparam logic signed [RateW-1:0] DecayThrRst   = 32'sd16777;
  localparam logic [CntW-1:0]         PatienceRst   = 16'd5;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_INIT_RATE,
    REG_WARMUP,
    REG_DECAY,
    REG_GROWTH,
    REG_GROWTH_THR,
    REG_DECAY_THR,
    REG_PATIENCE
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_POW,
    MUL_FIN,
    MUL_ADP,
    MUL_WRM
  } mul_op_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_POW,
    RES_FIN,
    RES_ADP,
    RES_DIV_LOAD
  } res_op_e;

  typedef struct packed {
    logic    start;
    logic    adapt_eval;
    logic    mul_en;
    mul_op_e mul_op;
    res_op_e res_op;
    logic    div_step;
    logic    div_end;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_last;
    logic fire;
    logic warm;
    logic div_last;
  } dp_status_t;

endpackage

@@ hw/rtl/lrs_if.sv @@
interface lrs_in_if import lrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IterW-1:0]        iteration;
  logic signed [RateW-1:0] rel_improvement;

  modport source (output valid, iteration, rel_improvement, input ready);
  modport sink (input valid, iteration, rel_improvement, output ready);
endinterface

interface lrs_out_if import lrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RateW-1:0] learning_rate;
  logic             saturated;

  modport source (output valid, learning_rate, saturated, input ready);
  modport sink (input valid, learning_rate, saturated, output ready);
endinterface

@@ hw/rtl/lrs_ctrl.sv @@
`include "learning_rate_scheduler_assert.svh"

module lrs_ctrl import lrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRANCH,
    ST_POW_MUL,
    ST_POW_RES,
    ST_FIN_MUL,
    ST_FIN_RES,
    ST_ADP_CHK,
    ST_ADP_MUL,
    ST_ADP_RES,
    ST_WRM_CHK,
    ST_WRM_MUL,
    ST_WRM_RES,
    ST_DIV,
    ST_DIV_END,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_op = MUL_POW;
    cmd_o.res_op = RES_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_BRANCH;
        end
      end
      ST_BRANCH: begin
        if (mode_i) begin
          cmd_o.adapt_eval = 1'b1;
          state_d          = ST_ADP_CHK;
        end else if (status_i.exp_zero) begin
          state_d = ST_FIN_MUL;
        end else begin
          state_d = ST_POW_MUL;
        end
      end
      ST_POW_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_POW;
        state_d      = ST_POW_RES;
      end
      ST_POW_RES: begin
        cmd_o.res_op = RES_POW;
        state_d      = status_i.exp_last ? ST_FIN_MUL : ST_POW_MUL;
      end
      ST_FIN_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_FIN;
        state_d      = ST_FIN_RES;
      end
      ST_FIN_RES: begin
        cmd_o.res_op = RES_FIN;
        state_d      = ST_WRM_CHK;
      end
      ST_ADP_CHK: begin
        state_d = status_i.fire ? ST_ADP_MUL : ST_WRM_CHK;
      end
      ST_ADP_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_ADP;
        state_d      = ST_ADP_RES;
      end
      ST_ADP_RES: begin
        cmd_o.res_op = RES_ADP;
        state_d      = ST_WRM_CHK;
      end
      ST_WRM_CHK: begin
        state_d = status_i.warm ? ST_WRM_MUL : ST_DONE;
      end
      ST_WRM_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_WRM;
        state_d      = ST_WRM_RES;
      end
      ST_WRM_RES: begin
        cmd_o.res_op = RES_DIV_LOAD;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd_o.div_end = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // Wait for the output register to drain before handing over the result.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `LRS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
                  !in_ready_o, "input accepted while a transaction is in flight")
  `LRS_ASSERT_IMP(a_load_into_free_slot, clk_i, rst_ni, cmd_o.out_load,
                  !out_valid_q || out_ready_i, "result overwrites a pending transaction")
  `LRS_ASSERT_NXT(a_div_ends, clk_i, rst_ni, state_q == ST_DIV && status_i.div_last,
                  state_q == ST_DIV_END, "divider overran its step count")

endmodule

@@ hw/rtl/lrs_dp.sv @@
`include "learning_rate_scheduler_assert.svh"

module lrs_dp import lrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic [IterW-1:0]        iteration_i,
  input  logic signed [RateW-1:0] rel_improvement_i,
  input  logic [RateW-1:0]        initial_rate_i,
  input  logic [IterW-1:0]        warmup_steps_i,
  input  logic [RateW-1:0]        decay_factor_i,
  input  logic [RateW-1:0]        growth_factor_i,
  input  logic signed [RateW-1:0] growth_threshold_i,
  input  logic signed [RateW-1:0] decay_threshold_i,
  input  logic [CntW-1:0]         patience_i,
  input  logic                    rate_load_i,
  input  logic [RateW-1:0]        rate_value_i,
  output logic [RateW-1:0]        learning_rate_o,
  output logic                    saturated_o
);

  localparam int unsigned ProdW = 2 * RateW;
  localparam int unsigned DivCntW = $clog2(RateW);

  // Round half up to Q8.24 and clamp; bit 32 flags the clamp.
  function automatic logic [RateW:0] qround(input logic [ProdW-1:0] p);
    logic [ProdW-1:0] s;
    s = p + ProdW'(64'h0080_0000);
    if (|s[ProdW-1:56]) begin
      qround = {1'b1, {RateW{1'b1}}};
    end else begin
      qround = {1'b0, s[55:24]};
    end
  endfunction

  // Persistent state.
  logic [RateW-1:0] current_rate_q;
  logic [CntW-1:0]  grow_cnt_q, decay_cnt_q;
  logic             fire_q, grow_sel_q;

  // Working registers.
  logic [IterW-1:0]        iter_q;
  logic signed [RateW-1:0] imp_q;
  logic [RateW-1:0]        base_q, acc_q, lr_q, quo_q;
  logic [IterW-1:0]        exp_q;
  logic                    sat_q;
  logic [ProdW-1:0]        prod_a_q, prod_b_q;
  logic [IterW-1:0]        rem_q;
  logic [DivCntW-1:0]      div_cnt_q;
  logic [RateW-1:0]        out_lr_q;
  logic                    out_sat_q;

  logic [RateW-1:0] mul_a, mul_b;
  logic [RateW:0]   rnd_a, rnd_b;
  logic [RateW-1:0] rem_sh;
  logic             rem_ge;
  logic [RateW-1:0] rem_sub;
  logic [CntW-1:0]  grow_inc, decay_inc;
  logic             imp_gt, imp_lt;

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_POW: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      MUL_FIN: begin
        mul_a = initial_rate_i;
        mul_b = acc_q;
      end
      MUL_ADP: begin
        mul_a = current_rate_q;
        mul_b = grow_sel_q ? growth_factor_i : decay_factor_i;
      end
      MUL_WRM: begin
        mul_a = lr_q;
        mul_b = {1'b0, iter_q};
      end
      default: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
    endcase
  end

  assign rnd_a = qround(prod_a_q);
  assign rnd_b = qround(prod_b_q);

  // One restoring division step; the remainder always stays below warmup_steps.
  assign rem_sh  = {rem_q, quo_q[RateW-1]};
  assign rem_ge  = rem_sh >= {1'b0, warmup_steps_i};
  assign rem_sub = rem_sh - {1'b0, warmup_steps_i};

  assign imp_gt    = imp_q > growth_threshold_i;
  assign imp_lt    = decay_threshold_i > imp_q;
  assign grow_inc  = (&grow_cnt_q) ? grow_cnt_q : grow_cnt_q + 1'b1;
  assign decay_inc = (&decay_cnt_q) ? decay_cnt_q : decay_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_rate_q <= InitRateRst;
      grow_cnt_q     <= '0;
      decay_cnt_q    <= '0;
      fire_q         <= 1'b0;
      grow_sel_q     <= 1'b0;
    end else begin
      if (rate_load_i) begin
        current_rate_q <= rate_value_i;
      end else if (cmd_i.res_op == RES_ADP) begin
        current_rate_q <= rnd_a[RateW-1:0];
      end
      if (cmd_i.adapt_eval) begin
        fire_q <= 1'b0;
        if (imp_gt) begin
          decay_cnt_q <= '0;
          grow_sel_q  <= 1'b1;
          if (grow_inc >= patience_i) begin
            fire_q     <= 1'b1;
            grow_cnt_q <= '0;
          end else begin
            grow_cnt_q <= grow_inc;
          end
        end else if (imp_lt) begin
          grow_cnt_q <= '0;
          grow_sel_q <= 1'b0;
          if (decay_inc >= patience_i) begin
            fire_q      <= 1'b1;
            decay_cnt_q <= '0;
          end else begin
            decay_cnt_q <= decay_inc;
          end
        end else begin
          grow_cnt_q  <= '0;
          decay_cnt_q <= '0;
        end
      end else if (cmd_i.start) begin
        fire_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      iter_q <= iteration_i;
      imp_q  <= rel_improvement_i;
      base_q <= decay_factor_i;
      acc_q  <= OneQ24;
      exp_q  <= iteration_i;
      sat_q  <= 1'b0;
    end
    if (cmd_i.adapt_eval) begin
      lr_q <= current_rate_q;
    end
    if (cmd_i.mul_en) begin
      prod_a_q <= mul_a * mul_b;
      prod_b_q <= base_q * base_q;
    end
    unique case (cmd_i.res_op)
      RES_NONE: ;
      RES_POW: begin
        // Square the base only while higher exponent bits remain.
        if (exp_q[0]) begin
          acc_q <= rnd_a[RateW-1:0];
        end
        if (|exp_q[IterW-1:1]) begin
          base_q <= rnd_b[RateW-1:0];
        end
        sat_q <= sat_q | (exp_q[0] & rnd_a[RateW]) | ((|exp_q[IterW-1:1]) & rnd_b[RateW]);
        exp_q <= exp_q >> 1;
      end
      RES_FIN, RES_ADP: begin
        lr_q  <= rnd_a[RateW-1:0];
        sat_q <= sat_q | rnd_a[RateW];
      end
      RES_DIV_LOAD: begin
        rem_q     <= prod_a_q[ProdW-2:RateW];
        quo_q     <= prod_a_q[RateW-1:0];
        div_cnt_q <= '0;
      end
      default: ;
    endcase
    if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? rem_sub[IterW-1:0] : rem_sh[IterW-1:0];
      quo_q     <= {quo_q[RateW-2:0], rem_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.div_end) begin
      lr_q <= quo_q;
    end
    if (cmd_i.out_load) begin
      out_lr_q  <= lr_q;
      out_sat_q <= sat_q;
    end
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_last = (exp_q[IterW-1:1] == '0);
  assign status_o.fire     = fire_q;
  assign status_o.warm     = iter_q < warmup_steps_i;
  assign status_o.div_last = &div_cnt_q;

  assign learning_rate_o = out_lr_q;
  assign saturated_o     = out_sat_q;

  `LRS_ASSERT_IMP(a_fire_clears_counters, clk_i, rst_ni, fire_q,
                  grow_cnt_q == '0 && decay_cnt_q == '0, "counter kept after rate change")
  `LRS_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, cmd_i.div_step,
                  rem_q < warmup_steps_i, "division remainder out of range")
  `LRS_ASSERT_NXT(a_rate_reload, clk_i, rst_ni, rate_load_i,
                  current_rate_q == $past(rate_value_i), "rate reload lost")

endmodule

@@ hw/rtl/learning_rate_scheduler.sv @@
// Learning rate scheduler with linear warmup.
// Input channel (in_ch_i): one transaction carries an iteration number and a
// signed Q8.24 relative loss improvement. Output channel (out_ch_o): one
// transaction per input, carrying the Q8.24 learning rate and a flag that is
// set when any product of that step was clamped to the maximum.
// Registers are written over the APB port at byte address 4*index. The user
// must write them only while the block is idle; the block itself does not
// enforce this. Writing initial_rate also reloads the kept rate. The
// exponential mode runs a power by squaring on two 32x32 multipliers; the
// adaptive mode adds a multiply only when the kept rate changes. During
// warmup a 32-step restoring divider scales the rate. One transaction is
// processed at a time; the next one is accepted as soon as the result is
// parked in the output register, even if it is not taken. When the receiver
// stalls, a second result waits in the datapath until the output register
// drains. Reset restores the config registers to defaults, sets the kept
// rate to the default initial rate and clears both counters.
module learning_rate_scheduler import lrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  lrs_in_if.sink           in_ch_i,
  lrs_out_if.source        out_ch_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers.
  logic                    mode_q;
  logic [RateW-1:0]        initial_rate_q;
  logic [IterW-1:0]        warmup_steps_q;
  logic [RateW-1:0]        decay_factor_q;
  logic [RateW-1:0]        growth_factor_q;
  logic signed [RateW-1:0] growth_threshold_q;
  logic signed [RateW-1:0] decay_threshold_q;
  logic [CntW-1:0]         patience_q;

  reg_idx_e   reg_idx;
  logic       cfg_write;
  dp_cmd_t    cmd;
  dp_status_t status;

  // The word address selects the register; the byte offset is ignored.
  assign reg_idx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q             <= ModeRst;
      initial_rate_q     <= InitRateRst;
      warmup_steps_q     <= WarmupRst;
      decay_factor_q     <= DecayRst;
      growth_factor_q    <= GrowthRst;
      growth_threshold_q <= GrowthThrRst;
      decay_threshold_q  <= DecayThrRst;
      patience_q         <= PatienceRst;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MODE:       mode_q             <= pwdata[0];
        REG_INIT_RATE:  initial_rate_q     <= pwdata;
        REG_WARMUP:     warmup_steps_q     <= pwdata[IterW-1:0];
        REG_DECAY:      decay_factor_q     <= pwdata;
        REG_GROWTH:     growth_factor_q    <= pwdata;
        REG_GROWTH_THR: growth_threshold_q <= pwdata;
        REG_DECAY_THR:  decay_threshold_q  <= pwdata;
        REG_PATIENCE:   patience_q         <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Read data is returned combinationally in the access cycle.
  always_comb begin
    unique case (reg_idx)
      REG_MODE:       prdata = {31'd0, mode_q};
      REG_INIT_RATE:  prdata = initial_rate_q;
      REG_WARMUP:     prdata = {1'b0, warmup_steps_q};
      REG_DECAY:      prdata = decay_factor_q;
      REG_GROWTH:     prdata = growth_factor_q;
      REG_GROWTH_THR: prdata = growth_threshold_q;
      REG_DECAY_THR:  prdata = decay_threshold_q;
      REG_PATIENCE:   prdata = {16'd0, patience_q};
      default:        prdata = '0;
    endcase
  end

  // The controller sequences the multiply, round and divide steps.
  lrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the kept rate, the patience counters and the
  // output register. The kept rate is reloaded from the written word itself,
  // since the initial rate register only takes it at the same edge.
  lrs_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .iteration_i        (in_ch_i.iteration),
    .rel_improvement_i  (in_ch_i.rel_improvement),
    .initial_rate_i     (initial_rate_q),
    .warmup_steps_i     (warmup_steps_q),
    .decay_factor_i     (decay_factor_q),
    .growth_factor_i    (growth_factor_q),
    .growth_threshold_i (growth_threshold_q),
    .decay_threshold_i  (decay_threshold_q),
    .patience_i         (patience_q),
    .rate_load_i        (cfg_write && (reg_idx == REG_INIT_RATE)),
    .rate_value_i       (pwdata),
    .learning_rate_o    (out_ch_o.learning_rate),
    .saturated_o        (out_ch_o.saturated)
  );

endmodule

@@ tb/sv/learning_rate_scheduler_tb.sv @@
module learning_rate_scheduler_tb import lrs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted transaction before the run is declared hung.
  // The slowest correct gap is a sender pause, a full warmup latency and a
  // receiver stall, and the long receiver hold-off below also stays well
  // under the limit.
  localparam int unsigned StallLimit  = 3000;
  // Cycles to keep watching after the last expected result, a bit over the
  // worst latency of the block.
  localparam int unsigned TailCycles  = 150;
  localparam int unsigned PhaseItems  = 60;
  localparam int unsigned PhaseCount  = 20;
  localparam logic [RateW-1:0] RateMax = 32'hFFFF_FFFF;
  localparam logic signed [RateW-1:0] ImpMax = 32'sh7FFF_FFFF;
  localparam logic signed [RateW-1:0] ImpMin = 32'sh8000_0000;

  // Values of the mode register.
  typedef enum logic {
    MODE_EXPONENTIAL = 1'b0,
    MODE_ADAPTIVE    = 1'b1
  } sched_mode_e;

  // Classes of loss improvement offered to the adaptive schedule.
  typedef enum logic [1:0] {
    IMP_GROW,
    IMP_DECAY,
    IMP_BETWEEN,
    IMP_NOISE
  } imp_kind_e;

  typedef struct packed {
    logic [RateW-1:0] learning_rate;
    logic             saturated;
  } lr_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  lrs_in_if  in_ch ();
  lrs_out_if out_ch ();

  learning_rate_scheduler DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, kept in step with every
  // write on the register port.
  logic                    cfg_mode;
  logic [RateW-1:0]        cfg_init_rate;
  logic [IterW-1:0]        cfg_warmup;
  logic [RateW-1:0]        cfg_decay;
  logic [RateW-1:0]        cfg_growth;
  logic signed [RateW-1:0] cfg_growth_thr;
  logic signed [RateW-1:0] cfg_decay_thr;
  logic [CntW-1:0]         cfg_patience;

  // Shadow copy of the adaptive schedule state.
  logic [RateW-1:0] kept_rate;
  logic [CntW-1:0]  growth_run;
  logic [CntW-1:0]  decay_run;

  // Set by any clamped product while one step is being predicted.
  logic step_clamped;

  // Expected results, oldest first.
  lr_result_t lr_expect_q[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  // When set, both sides run without idle cycles.
  bit          no_idle = 1'b0;
  // Requested receiver hold-off in cycles, consumed by the result sink.
  int unsigned result_hold = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Q8.24 product with half-up rounding; anything that does not fit in 32
  // bits is clamped to the maximum and flags the step.
  function automatic logic [RateW-1:0] q_mul(input logic [RateW-1:0] a,
                                             input logic [RateW-1:0] b);
    logic [63:0] prod;
    prod = ({32'd0, a} * {32'd0, b} + 64'h0080_0000) >> 24;
    if (prod[63:32] != 32'd0) begin
      step_clamped = 1'b1;
      return RateMax;
    end
    return prod[31:0];
  endfunction

  // Power by squaring from the least significant exponent bit up. The base
  // is squared only while higher bits remain, so a clamp on a square that
  // would never be used does not flag the step.
  function automatic logic [RateW-1:0] q_pow(input logic [RateW-1:0] base,
                                             input logic [IterW-1:0] expo);
    logic [RateW-1:0] acc;
    logic [RateW-1:0] sq;
    logic [IterW-1:0] rest;
    acc  = OneQ24;
    sq   = base;
    rest = expo;
    while (rest != '0) begin
      if (rest[0]) begin
        acc = q_mul(acc, sq);
      end
      rest = rest >> 1;
      if (rest != '0) begin
        sq = q_mul(sq, sq);
      end
    end
    return acc;
  endfunction

  // Works out the learning rate for one accepted transaction and advances the
  // shadow schedule state.
  function automatic lr_result_t predict_rate(input logic [IterW-1:0] iter,
                                              input logic signed [RateW-1:0] imp);
    lr_result_t  res;
    logic [RateW-1:0] lr;
    logic [63:0] scaled;
    step_clamped = 1'b0;
    if (cfg_mode == MODE_EXPONENTIAL) begin
      lr = q_mul(cfg_init_rate, q_pow(cfg_decay, iter));
    end else begin
      if (imp > cfg_growth_thr) begin
        decay_run = '0;
        if (growth_run != '1) begin
          growth_run = growth_run + 1'b1;
        end
        // A patience of zero makes every qualifying step fire.
        if (growth_run >= cfg_patience) begin
          kept_rate  = q_mul(kept_rate, cfg_growth);
          growth_run = '0;
        end
      end else if (cfg_decay_thr > imp) begin
        growth_run = '0;
        if (decay_run != '1) begin
          decay_run = decay_run + 1'b1;
        end
        if (decay_run >= cfg_patience) begin
          kept_rate = q_mul(kept_rate, cfg_decay);
          decay_run = '0;
        end
      end else begin
        growth_run = '0;
        decay_run  = '0;
      end
      lr = kept_rate;
    end
    // Linear warmup truncates and can never exceed the unscaled rate.
    if (iter < cfg_warmup) begin
      scaled = ({32'd0, lr} * {33'd0, iter}) / {33'd0, cfg_warmup};
      lr     = scaled[31:0];
    end
    res.learning_rate = lr;
    res.saturated     = step_clamped;
    return res;
  endfunction

  // Follows a register write into the shadow copy. Writing the initial rate
  // also reloads the kept rate, while both run counters are left alone.
  function automatic void apply_config(input reg_idx_e idx, input logic [31:0] value);
    case (idx)
      REG_MODE:       cfg_mode       = value[0];
      REG_INIT_RATE: begin
        cfg_init_rate = value;
        kept_rate     = value;
      end
      REG_WARMUP:     cfg_warmup     = value[IterW-1:0];
      REG_DECAY:      cfg_decay      = value;
      REG_GROWTH:     cfg_growth     = value;
      REG_GROWTH_THR: cfg_growth_thr = value;
      REG_DECAY_THR:  cfg_decay_thr  = value;
      REG_PATIENCE:   cfg_patience   = value[CntW-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Register write over the configuration port: a setup cycle, then an access
  // cycle that completes at the edge where pready is seen high; the port is then
  // left idle so that back-to-back writes never drive it twice in one step.
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_config(idx, value);
    @(posedge clk_i);
  endtask

  // Offers one transaction after a random gap and waits for it to be taken.
  // Valid is left high at the accept edge; the next call either keeps it high
  // for a back-to-back offer or lowers it for a gap, so valid never gets two
  // assignments in one time step.
  task automatic send_rate_request(input logic [IterW-1:0] iter,
                                   input logic signed [RateW-1:0] imp);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.iteration       <= iter;
    in_ch.rel_improvement <= imp;
    do @(posedge clk_i); while (!in_ch.ready);
    lr_expect_q.push_back(predict_rate(iter, imp));
  endtask

  // Stops offering and waits until every expected result has come back. Every
  // transaction yields a result, so the block is idle afterwards.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (lr_expect_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Mostly small iterations keep the power short; the rest cover the extremes
  // and every bit of the field, plus the edge of the warmup window.
  function automatic logic [IterW-1:0] pick_iteration();
    logic [IterW-1:0] iter;
    case ($urandom_range(0, 7))
      0:       iter = IterW'($urandom);
      1:       iter = '1;
      2:       iter = '0;
      3: begin
        if (cfg_warmup != '0) begin
          iter = cfg_warmup - 1'b1 + IterW'($urandom_range(0, 2));
        end else begin
          iter = IterW'($urandom_range(0, 64));
        end
      end
      default: iter = IterW'($urandom_range(0, 64));
    endcase
    return iter;
  endfunction

  // Factors cluster around 1.0 so that rates move slowly, with the extremes
  // and fully random values mixed in.
  function automatic logic [RateW-1:0] pick_factor();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RateMax;
      2:       return OneQ24;
      3:       return $urandom;
      default: return OneQ24 - 32'h0010_0000 + $urandom_range(0, 32'h0020_0000);
    endcase
  endfunction

  function automatic logic signed [RateW-1:0] pick_threshold();
    case ($urandom_range(0, 6))
      0:       return ImpMax;
      1:       return ImpMin;
      2:       return $urandom;
      default: return RateW'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  // Draws a loss improvement of the requested class against the current
  // thresholds. Where a class is empty, the nearest value on the boundary is
  // used and simply lands in the neighboring class.
  function automatic logic signed [RateW-1:0] gen_improvement(input imp_kind_e kind);
    longint v;
    case (kind)
      IMP_GROW: begin
        if (cfg_growth_thr == ImpMax) begin
          v = longint'(ImpMax);
        end else if ($urandom_range(0, 7) == 0) begin
          v = longint'(cfg_growth_thr) + 1 +
              (longint'($urandom) % (longint'(ImpMax) - longint'(cfg_growth_thr)));
        end else begin
          v = longint'(cfg_growth_thr) + longint'($urandom_range(1, 4096));
          if (v > longint'(ImpMax)) v = longint'(ImpMax);
        end
      end
      IMP_DECAY: begin
        if (cfg_decay_thr == ImpMin) begin
          v = longint'(ImpMin);
        end else if ($urandom_range(0, 7) == 0) begin
          v = longint'(cfg_decay_thr) - 1 -
              (longint'($urandom) % (longint'(cfg_decay_thr) - longint'(ImpMin)));
        end else begin
          v = longint'(cfg_decay_thr) - longint'($urandom_range(1, 4096));
          if (v < longint'(ImpMin)) v = longint'(ImpMin);
        end
      end
      IMP_BETWEEN: begin
        if (cfg_decay_thr <= cfg_growth_thr) begin
          v = longint'(cfg_decay_thr) + (longint'($urandom) %
              (longint'(cfg_growth_thr) - longint'(cfg_decay_thr) + 1));
        end else begin
          v = longint'(cfg_growth_thr);
        end
      end
      default: v = longint'($urandom);
    endcase
    return RateW'(v);
  endfunction

  // Writes every register with a freshly drawn value. Extremes come up often
  // enough that each is hit over the phases of the random test.
  task automatic draw_schedule_config();
    logic [RateW-1:0] rate;
    logic [IterW-1:0] warm;
    logic [CntW-1:0]  pat;
    case ($urandom_range(0, 6))
      0:       rate = '0;
      1:       rate = RateMax;
      2:       rate = InitRateRst;
      3:       rate = $urandom;
      default: rate = $urandom_range(32'h0010_0000, 32'h0400_0000);
    endcase
    case ($urandom_range(0, 7))
      0:       warm = '1;
      1:       warm = IterW'($urandom);
      2, 3:    warm = IterW'($urandom_range(1, 64));
      default: warm = '0;
    endcase
    case ($urandom_range(0, 7))
      0:       pat = '1;
      1:       pat = CntW'($urandom);
      default: pat = CntW'($urandom_range(0, 6));
    endcase
    apb_write(REG_MODE, ($urandom_range(0, 9) < 6) ? 32'(MODE_ADAPTIVE)
                                                   : 32'(MODE_EXPONENTIAL));
    apb_write(REG_INIT_RATE, rate);
    apb_write(REG_WARMUP, 32'(warm));
    apb_write(REG_DECAY, pick_factor());
    apb_write(REG_GROWTH, pick_factor());
    apb_write(REG_GROWTH_THR, pick_threshold());
    apb_write(REG_DECAY_THR, pick_threshold());
    apb_write(REG_PATIENCE, 32'(pat));
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Exponential cooling from the reset configuration, then the corners of
  // the power: a zero exponent, the largest exponent, a factor of zero, a
  // factor of exactly 1.0 on the largest rate, and a product that clamps.
  task automatic test_exponential();
    send_rate_request(31'd0, 32'sd0);
    send_rate_request(31'd1, 32'sd0);
    send_rate_request(31'd2, ImpMax);
    send_rate_request('1, ImpMin);
    send_rate_request(31'd37, $urandom);
    wait_for_results();
    apb_write(REG_DECAY, RateMax);
    apb_write(REG_INIT_RATE, RateMax);
    send_rate_request(31'd0, 32'sd0);
    send_rate_request(31'd1, 32'sd0);
    wait_for_results();
    apb_write(REG_DECAY, '0);
    send_rate_request(31'd3, 32'sd0);
    wait_for_results();
    apb_write(REG_DECAY, OneQ24);
    send_rate_request('1, 32'sd0);
  endtask

  // Warmup scaling at the start, the middle and both sides of the window
  // edge, then the widest window on the largest rate.
  task automatic test_warmup();
    wait_for_results();
    apb_write(REG_INIT_RATE, 32'h0300_0000);
    apb_write(REG_WARMUP, 32'd100);
    send_rate_request(31'd0, 32'sd0);
    send_rate_request(31'd50, 32'sd0);
    send_rate_request(31'd99, 32'sd0);
    send_rate_request(31'd100, 32'sd0);
    wait_for_results();
    apb_write(REG_WARMUP, 32'h7FFF_FFFF);
    apb_write(REG_INIT_RATE, RateMax);
    send_rate_request(31'h7FFF_FFFE, 32'sd0);
  endtask

  // Adaptive schedule: growth and decay after patience steps, values equal to
  // a threshold counting as in between, a patience of zero, a reload of the
  // initial rate in the middle of a run, and a growth that clamps.
  task automatic test_adaptive();
    wait_for_results();
    apb_write(REG_MODE, 32'(MODE_ADAPTIVE));
    apb_write(REG_WARMUP, '0);
    apb_write(REG_INIT_RATE, OneQ24);
    apb_write(REG_GROWTH, 32'h0200_0000);
    apb_write(REG_DECAY, 32'h0080_0000);
    apb_write(REG_GROWTH_THR, 32'h0001_0000);
    apb_write(REG_DECAY_THR, 32'hFFFF_0000);
    apb_write(REG_PATIENCE, 32'd2);
    send_rate_request(31'd0, ImpMax);
    send_rate_request(31'd1, 32'sh0001_0001);
    send_rate_request(31'd2, 32'sh0001_0000);
    send_rate_request(31'd3, ImpMin);
    send_rate_request(31'd4, 32'shFFFE_FFFF);
    send_rate_request(31'd5, 32'shFFFF_0000);
    wait_for_results();
    apb_write(REG_PATIENCE, '0);
    send_rate_request(31'd6, 32'sh0100_0000);
    wait_for_results();
    apb_write(REG_PATIENCE, 32'd3);
    send_rate_request(31'd7, 32'sh0100_0000);
    send_rate_request(31'd8, 32'sh0100_0000);
    wait_for_results();
    // The run counters survive the reload, so the next growth fires.
    apb_write(REG_INIT_RATE, 32'h0080_0000);
    send_rate_request(31'd9, 32'sh0100_0000);
    wait_for_results();
    apb_write(REG_INIT_RATE, RateMax);
    apb_write(REG_PATIENCE, 32'd1);
    send_rate_request(31'd10, ImpMax);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the output register and the datapath fill up and the
  // input stalls. The sender then pauses until every result is back.
  task automatic test_backpressure();
    wait_for_results();
    apb_write(REG_MODE, 32'(MODE_EXPONENTIAL));
    apb_write(REG_INIT_RATE, OneQ24);
    apb_write(REG_DECAY, 32'h00FF_0000);
    no_idle     = 1'b1;
    result_hold = 300;
    for (int i = 0; i < 24; i++) begin
      send_rate_request(IterW'($urandom_range(0, 40)), $urandom);
    end
    wait_for_results();
    no_idle = 1'b0;
  endtask

  // Random phases, each under a freshly drawn configuration. In adaptive mode
  // most improvements come in runs of one class that can reach a small
  // patience, with a little noise mixed in.
  task automatic test_random();
    int unsigned n;
    int unsigned run_len;
    imp_kind_e   kind;
    logic signed [RateW-1:0] imp;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_for_results();
      draw_schedule_config();
      no_idle = (phase % 5 == 3);
      if (phase % 7 == 5) begin
        result_hold = $urandom_range(100, 300);
      end
      n = 0;
      while (n < PhaseItems) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: kind = IMP_GROW;
          4, 5, 6, 7: kind = IMP_DECAY;
          8:          kind = IMP_BETWEEN;
          default:    kind = IMP_NOISE;
        endcase
        run_len = $urandom_range(1, ((cfg_patience > 8) ? 8 : cfg_patience) + 2);
        for (int k = 0; k < run_len && n < PhaseItems; k++) begin
          imp = ($urandom_range(0, 9) == 0) ? gen_improvement(IMP_NOISE)
                                            : gen_improvement(kind);
          send_rate_request(pick_iteration(), imp);
          n++;
          // Now and then the sender waits for the block to drain completely.
          if (n == PhaseItems / 2 && $urandom_range(0, 2) == 0) begin
            wait_for_results();
          end
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: stalls a random number of cycles before each result unless no_idle
  // is set, or holds off for a long stretch when a test asks for it.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (result_hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (result_hold) @(posedge clk_i);
        result_hold = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    lr_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (lr_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: rate %h sat %b",
                                  out_ch.learning_rate, out_ch.saturated));
      end else begin
        want = lr_expect_q.pop_front();
        if (out_ch.learning_rate !== want.learning_rate) begin
          report_mismatch($sformatf("learning_rate %h, expected %h",
                                    out_ch.learning_rate, want.learning_rate));
        end
        if (out_ch.saturated !== want.saturated) begin
          report_mismatch($sformatf("saturated %b, expected %b (rate %h)",
                                    out_ch.saturated, want.saturated,
                                    want.learning_rate));
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for
  // too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("learning_rate_scheduler regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.iteration       <= '0;
    in_ch.rel_improvement <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;

    // The shadow state starts from the documented reset values.
    cfg_mode       = ModeRst;
    cfg_init_rate  = InitRateRst;
    cfg_warmup     = WarmupRst;
    cfg_decay      = DecayRst;
    cfg_growth     = GrowthRst;
    cfg_growth_thr = GrowthThrRst;
    cfg_decay_thr  = DecayThrRst;
    cfg_patience   = PatienceRst;
    kept_rate      = InitRateRst;
    growth_run     = '0;
    decay_run      = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_exponential();
    test_warmup();
    test_adaptive();
    test_backpressure();
    test_random();

    // Drain, then keep watching for stray results.
    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("learning_rate_scheduler regression: pass");
    end else begin
      $display("learning_rate_scheduler regression: fail");
    end
    $finish;
  end

endmodule
